>>> hdl/block_average_pixelate_defines.svh
// Assertion macros used by block_average_pixelate.sv.
// Each expects clk and rst_n in scope.
`ifndef BLOCK_AVERAGE_PIXELATE_DEFINES_SVH
`define BLOCK_AVERAGE_PIXELATE_DEFINES_SVH

// Same-cycle implication
`define BAP_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication
`define BAP_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> hdl/bap_pkg.sv
package bap_pkg;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = 20;
    localparam int QUO_W      = 8;
    localparam int IDX_W      = 10;
    localparam int MAX_HEIGHT = 1024;
    localparam int Y_W        = 10;
    localparam int HC_W       = 11;
    localparam int CFG_DIM_W  = 11;
    localparam int CFG_TILE_W = 7;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MAX_TILE  = 64;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    localparam logic [CFG_DIM_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [CFG_DIM_W-1:0]  RST_IMAGE_HEIGHT = 11'd480;
    localparam logic [CFG_TILE_W-1:0] RST_TILE_SIZE    = 7'd8;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_IMAGE_WIDTH  = 2'd0;
    localparam reg_idx_t REG_IMAGE_HEIGHT = 2'd1;
    localparam reg_idx_t REG_TILE_SIZE    = 2'd2;

endpackage

>>> hdl/bap_ram.sv
module bap_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/block_average_pixelate.sv
// Channel   Direction  Handshake                  Payload
// pixel     in         pixel_valid / pixel_stall  pixel, frame_start
// tile      out        tile_valid / tile_stall    tile_average, tile_column, tile_row, frame_last
// config    in         APB (psel/penable/pready)  image_width, image_height, tile_size
//
// A pixel that closes no tile is accepted with the column-sum RAM read, then
// added and written back. A pixel that closes a tile does the same, then runs
// 9 steps of the radix-2 divider (sum by tile area) and loads the output
// register. A stalled output register holds the divider result until free.
// Reset sets state, counters, tile_valid and config; the column-sum RAM is not cleared.
`include "block_average_pixelate_defines.svh"

module block_average_pixelate
    import bap_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_TILE  = DEF_MAX_TILE
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  logic [PIX_W-1:0]      pixel,
    input  logic                  frame_start,

    output logic                  tile_valid,
    input  logic                  tile_stall,
    output logic [QUO_W-1:0]      tile_average,
    output logic [IDX_W-1:0]      tile_column,
    output logic [IDX_W-1:0]      tile_row,
    output logic                  frame_last
);

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int TW    = (MAX_TILE > 1) ? $clog2(MAX_TILE) : 1;
    localparam int SW    = $clog2(MAX_TILE + 1);
    localparam int AREAW = 2 * SW;
    localparam int DVW   = AREAW + QUO_W;
    localparam int CMPW  = (SUM_W > DVW) ? SUM_W : DVW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [3:0] DIV_FIRST = 4'(QUO_W);

    // configuration registers
    logic [CFG_DIM_W-1:0]  image_width_reg,  image_width_next;
    logic [CFG_DIM_W-1:0]  image_height_reg, image_height_next;
    logic [CFG_TILE_W-1:0] tile_size_reg,    tile_size_next;
    logic                  cfg_write;

    // clamped settings
    logic [WW-1:0]    w_c;
    logic [HC_W-1:0]  h_c;
    logic [SW-1:0]    s_c;
    logic [XW-1:0]    w_m1_reg;
    logic [Y_W-1:0]   h_m1_reg;
    logic [TW-1:0]    s_m1_reg;
    logic [AREAW-1:0] area_reg;

    // position
    logic [1:0]       state_reg,  state_next;
    logic [XW-1:0]    pixel_x_reg, pixel_x_next;
    logic [Y_W-1:0]   pixel_y_reg, pixel_y_next;
    logic [TW-1:0]    x_in_tile_reg, x_in_tile_next;
    logic [TW-1:0]    y_in_tile_reg, y_in_tile_next;
    logic [XW-1:0]    tile_x_reg, tile_x_next;
    logic [Y_W-1:0]   tile_y_reg, tile_y_next;
    logic [PIX_W-1:0] pixel_reg, pixel_next;

    // result in flight
    logic [IDX_W-1:0] res_col_reg, res_col_next;
    logic [IDX_W-1:0] res_row_reg, res_row_next;
    logic             res_last_reg, res_last_next;

    // divider
    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [DVW-1:0]   dvs_reg, dvs_next;
    logic [QUO_W:0]   quo_reg, quo_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic             div_ge;

    // output register
    logic             tile_valid_reg, tile_valid_next;
    logic [QUO_W-1:0] tile_average_reg, tile_average_next;
    logic [IDX_W-1:0] tile_column_reg, tile_column_next;
    logic [IDX_W-1:0] tile_row_reg, tile_row_next;
    logic             frame_last_reg, frame_last_next;
    logic             out_free;

    // accumulator RAM
    logic             ram_we;
    logic [XW-1:0]    ram_raddr;
    logic [SUM_W-1:0] ram_rdata;
    logic [SUM_W-1:0] sum;
    logic [SUM_W:0]   sum_wide;

    logic in_accept;
    logic x_end, y_end, x_last, y_last, first_pix, res_hit;

    // ---------------------------------------------------------------- config
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        tile_size_next    = tile_size_reg;
        prdata            = '0;
        if (cfg_write)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_IMAGE_WIDTH:  image_width_next  = pwdata[CFG_DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_next = pwdata[CFG_DIM_W-1:0];
                REG_TILE_SIZE:    tile_size_next    = pwdata[CFG_TILE_W-1:0];
                default: ;
            endcase
        end
        unique case (reg_idx_t'(paddr[3:2]))
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height_reg);
            REG_TILE_SIZE:    prdata = APB_DATA_W'(tile_size_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            tile_size_reg    <= RST_TILE_SIZE;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            tile_size_reg    <= tile_size_next;
        end
    end

    // clamp width, height and tile edge
    always_comb
    begin
        if (image_width_reg == '0)
            w_c = WW'(1);
        else if (image_width_reg > MAX_WIDTH)
            w_c = WW'(MAX_WIDTH);
        else
            w_c = WW'(image_width_reg);

        if (image_height_reg == '0)
            h_c = HC_W'(1);
        else if (image_height_reg > MAX_HEIGHT)
            h_c = HC_W'(MAX_HEIGHT);
        else
            h_c = image_height_reg;

        s_c = SW'(MAX_TILE);
        if (tile_size_reg < MAX_TILE)
            s_c = SW'(tile_size_reg);
        if (w_c < s_c)
            s_c = SW'(w_c);
        if (h_c < s_c)
            s_c = SW'(h_c);
        if (tile_size_reg == '0)
            s_c = SW'(1);
    end

    // registered clamped settings; writes must only come while idle, which the block does not enforce
    always_ff @(posedge clk)
    begin
        w_m1_reg <= XW'(w_c - 1'b1);
        h_m1_reg <= Y_W'(h_c - 1'b1);
        s_m1_reg <= TW'(s_c - 1'b1);
        area_reg <= AREAW'(s_c) * AREAW'(s_c);
    end

    // ------------------------------------------------------------ datapath
    assign in_accept   = pixel_valid && !pixel_stall;
    assign pixel_stall = (state_reg != ST_IDLE);
    assign out_free    = !tile_valid_reg || !tile_stall;

    assign ram_raddr = frame_start ? '0 : tile_x_reg;
    assign ram_we    = (state_reg == ST_READ);

    assign first_pix = (x_in_tile_reg == '0) && (y_in_tile_reg == '0);
    assign sum_wide  = {1'b0, ram_rdata} + (SUM_W + 1)'(pixel_reg);

    always_comb
    begin
        if (first_pix)
            sum = SUM_W'(pixel_reg);
        else if (sum_wide[SUM_W])
            sum = SUM_MAX;
        else
            sum = sum_wide[SUM_W-1:0];
    end

    assign x_end   = pixel_x_reg >= w_m1_reg;
    assign y_end   = pixel_y_reg >= h_m1_reg;
    assign x_last  = x_end || (x_in_tile_reg >= s_m1_reg);
    assign y_last  = y_end || (y_in_tile_reg >= s_m1_reg);
    assign res_hit = x_last && y_last;

    assign div_ge = CMPW'(rem_reg) >= CMPW'(dvs_reg);

    bap_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_column_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tile_x_reg),
        .wdata (sum),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next        = state_reg;
        pixel_x_next      = pixel_x_reg;
        pixel_y_next      = pixel_y_reg;
        x_in_tile_next    = x_in_tile_reg;
        y_in_tile_next    = y_in_tile_reg;
        tile_x_next       = tile_x_reg;
        tile_y_next       = tile_y_reg;
        pixel_next        = pixel_reg;
        res_col_next      = res_col_reg;
        res_row_next      = res_row_reg;
        res_last_next     = res_last_reg;
        rem_next          = rem_reg;
        dvs_next          = dvs_reg;
        quo_next          = quo_reg;
        cnt_next          = cnt_reg;
        tile_valid_next   = tile_valid_reg && tile_stall;
        tile_average_next = tile_average_reg;
        tile_column_next  = tile_column_reg;
        tile_row_next     = tile_row_reg;
        frame_last_next   = frame_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    pixel_next = pixel;
                    if (frame_start)
                    begin
                        pixel_x_next   = '0;
                        pixel_y_next   = '0;
                        x_in_tile_next = '0;
                        y_in_tile_next = '0;
                        tile_x_next    = '0;
                        tile_y_next    = '0;
                    end
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                // hold the finished tile's place before the counters move on
                res_col_next  = IDX_W'(tile_x_reg);
                res_row_next  = IDX_W'(tile_y_reg);
                res_last_next = x_end && y_end;
                rem_next      = sum;
                dvs_next      = {area_reg, QUO_W'(0)};
                quo_next      = '0;
                cnt_next      = DIV_FIRST;
                state_next    = res_hit ? ST_DIV : ST_IDLE;

                if (x_end)
                begin
                    pixel_x_next   = '0;
                    x_in_tile_next = '0;
                    tile_x_next    = '0;
                    if (y_end)
                    begin
                        pixel_y_next   = '0;
                        y_in_tile_next = '0;
                        tile_y_next    = '0;
                    end
                    else
                    begin
                        pixel_y_next = pixel_y_reg + 1'b1;
                        if (y_in_tile_reg >= s_m1_reg)
                        begin
                            y_in_tile_next = '0;
                            tile_y_next    = tile_y_reg + 1'b1;
                        end
                        else
                        begin
                            y_in_tile_next = y_in_tile_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    pixel_x_next = pixel_x_reg + 1'b1;
                    if (x_in_tile_reg >= s_m1_reg)
                    begin
                        x_in_tile_next = '0;
                        tile_x_next    = tile_x_reg + 1'b1;
                    end
                    else
                    begin
                        x_in_tile_next = x_in_tile_reg + 1'b1;
                    end
                end
            end

            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle; top bit flags saturation
                if (div_ge)
                    rem_next = SUM_W'(CMPW'(rem_reg) - CMPW'(dvs_reg));
                quo_next = {quo_reg[QUO_W-1:0], div_ge};
                dvs_next = dvs_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    tile_valid_next   = 1'b1;
                    tile_average_next = quo_reg[QUO_W] ? '1 : quo_reg[QUO_W-1:0];
                    tile_column_next  = res_col_reg;
                    tile_row_next     = res_row_reg;
                    frame_last_next   = res_last_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pixel_x_reg    <= '0;
            pixel_y_reg    <= '0;
            x_in_tile_reg  <= '0;
            y_in_tile_reg  <= '0;
            tile_x_reg     <= '0;
            tile_y_reg     <= '0;
            cnt_reg        <= '0;
            tile_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pixel_x_reg    <= pixel_x_next;
            pixel_y_reg    <= pixel_y_next;
            x_in_tile_reg  <= x_in_tile_next;
            y_in_tile_reg  <= y_in_tile_next;
            tile_x_reg     <= tile_x_next;
            tile_y_reg     <= tile_y_next;
            cnt_reg        <= cnt_next;
            tile_valid_reg <= tile_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg        <= pixel_next;
        res_col_reg      <= res_col_next;
        res_row_reg      <= res_row_next;
        res_last_reg     <= res_last_next;
        rem_reg          <= rem_next;
        dvs_reg          <= dvs_next;
        quo_reg          <= quo_next;
        tile_average_reg <= tile_average_next;
        tile_column_reg  <= tile_column_next;
        tile_row_reg     <= tile_row_next;
        frame_last_reg   <= frame_last_next;
    end

    assign tile_valid   = tile_valid_reg;
    assign tile_average = tile_average_reg;
    assign tile_column  = tile_column_reg;
    assign tile_row     = tile_row_reg;
    assign frame_last   = frame_last_reg;

    // ------------------------------------------------------------ checks
    `BAP_ASSERT_NEXT(a_accept_writes_back, in_accept, ram_we,
        "accepted request did not write its column sum back")
    `BAP_ASSERT_NEXT(a_no_tile_returns_idle, (state_reg == ST_READ) && !res_hit,
        state_reg == ST_IDLE, "pixel without finished tile did not return to idle")
    `BAP_ASSERT_NOW(a_div_count_range, state_reg == ST_DIV, cnt_reg <= DIV_FIRST,
        "divider step count out of range")
    `BAP_ASSERT_NEXT(a_done_loads_output, (state_reg == ST_DONE) && out_free,
        tile_valid_reg && (state_reg == ST_IDLE), "finished tile not loaded into output")

endmodule
